/* rtl/tcon_pkg.sv */
// Shared constants for the text console character engine.
package tcon_pkg;

    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int DATA_W     = 16;
    localparam int ADDR_W     = 11;
    localparam int TAB_SPACES = 8;
    localparam int TAB_CNT_W  = 3;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd13;

    localparam logic [CHAR_W-1:0] FIRST_PRINTABLE = 8'd32;
    localparam logic [CHAR_W-1:0] LAST_PRINTABLE  = 8'd126;
    localparam logic [CHAR_W-1:0] CODE_SPACE      = 8'd32;
    localparam logic [CHAR_W-1:0] CODE_BACKSPACE  = 8'd8;
    localparam logic [CHAR_W-1:0] CODE_TAB        = 8'd9;
    localparam logic [CHAR_W-1:0] CODE_NEWLINE    = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_FORM_FEED  = 8'd12;
    localparam logic [CHAR_W-1:0] CODE_CR         = 8'd13;

    localparam logic [TAB_CNT_W-1:0] TAB_LAST = 3'(TAB_SPACES - 1);

endpackage

/* rtl/text_console_char_engine.sv */
// Text console character engine: cursor tracking and cell write generation.
// Result path: decode and cell address in S_CALC, cursor position in S_POS,
//   then the result is held in S_OUT until transfer; one item at a time,
//   as input is accepted only in S_IDLE.
//   The single row*COLUMNS+col unit is reused for the cell and cursor addresses.
// Reset: synchronous active low; cursor homed, attribute = 13, no result pending.
module text_console_char_engine #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // attribute register write
    input  logic                            i_text_attribute_we,
    input  logic [tcon_pkg::ATTR_W-1:0]     i_text_attribute,
    // character input
    input  logic                            i_char_code_valid,
    output logic                            o_char_code_ready,
    input  logic [tcon_pkg::CHAR_W-1:0]     i_char_code,
    // results
    output logic                            o_result_valid,
    input  logic                            i_result_ready,
    output logic                            o_cell_write,
    output logic                            o_clear_all,
    output logic [tcon_pkg::ADDR_W-1:0]     o_cell_addr,
    output logic [tcon_pkg::DATA_W-1:0]     o_cell_data,
    output logic [tcon_pkg::ADDR_W-1:0]     o_cursor_pos,
    output logic                            o_last_of_run
);
    import tcon_pkg::*;

    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int POS_W = ROW_W + COL_W;
    localparam int EXT_W = (POS_W > ADDR_W) ? POS_W : ADDR_W;

    // sequencer codes
    localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a character
    localparam logic [1:0] S_CALC = 2'd1;  // decode, cell address, cursor move
    localparam logic [1:0] S_POS  = 2'd2;  // new cursor position
    localparam logic [1:0] S_OUT  = 2'd3;  // result held until transfer

    logic [1:0]           r_state, n_state;
    logic [CHAR_W-1:0]    r_code;
    logic [ATTR_W-1:0]    r_attr;
    logic [ROW_W-1:0]     r_row, n_row;
    logic [COL_W-1:0]     r_col, n_col;
    logic [TAB_CNT_W-1:0] r_tab_cnt;

    logic                 r_cell_write, n_cell_write;
    logic                 r_clear_all, n_clear_all;
    logic [ADDR_W-1:0]    r_cell_addr, n_cell_addr;
    logic [DATA_W-1:0]    r_cell_data, n_cell_data;
    logic [ADDR_W-1:0]    r_cursor_pos;
    logic                 r_last, n_last;

    // shared position unit: row * COLUMNS + col of the live cursor
    logic [POS_W-1:0]     w_pos_full;
    logic [EXT_W-1:0]     w_pos_ext;
    logic [ADDR_W-1:0]    w_pos;

    assign w_pos_full = POS_W'(r_row) * POS_W'(COLUMNS) + POS_W'(r_col);
    assign w_pos_ext  = EXT_W'(w_pos_full);
    assign w_pos      = w_pos_ext[ADDR_W-1:0];

    // column/row advance with wrap, no scrolling
    logic [COL_W:0]       w_col_inc;
    logic [ROW_W:0]       w_row_inc;
    logic [ROW_W-1:0]     w_row_next;
    logic                 w_col_wrap;

    assign w_col_inc  = {1'b0, r_col} + 1'b1;
    assign w_row_inc  = {1'b0, r_row} + 1'b1;
    assign w_col_wrap = (w_col_inc >= (COL_W+1)'(COLUMNS));
    assign w_row_next = (w_row_inc >= (ROW_W+1)'(ROWS)) ? '0 : w_row_inc[ROW_W-1:0];

    logic w_printable, w_is_tab, w_accept, w_out_xfer;

    assign w_printable = (r_code >= FIRST_PRINTABLE) && (r_code <= LAST_PRINTABLE);
    assign w_is_tab    = (r_code == CODE_TAB);
    assign w_accept    = i_char_code_valid && o_char_code_ready;
    assign w_out_xfer  = o_result_valid && i_result_ready;

    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_col        = r_col;
        n_cell_write = r_cell_write;
        n_clear_all  = r_clear_all;
        n_cell_addr  = r_cell_addr;
        n_cell_data  = r_cell_data;
        n_last       = r_last;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                // defaults: cursor-only result
                n_cell_write = 1'b0;
                n_clear_all  = 1'b0;
                n_cell_addr  = '0;
                n_cell_data  = '0;
                n_last       = 1'b1;
                n_state      = S_POS;
                if (w_printable || w_is_tab) begin
                    n_cell_write = 1'b1;
                    n_cell_addr  = w_pos;
                    n_cell_data  = {r_attr, (w_is_tab ? CODE_SPACE : r_code)};
                    n_last       = !w_is_tab || (r_tab_cnt == TAB_LAST);
                    if (w_col_wrap) begin
                        n_col = '0;
                        n_row = w_row_next;
                    end else begin
                        n_col = w_col_inc[COL_W-1:0];
                    end
                end else begin
                    priority case (r_code)
                        CODE_NEWLINE: begin
                            n_col = '0;
                            n_row = w_row_next;
                        end
                        CODE_CR: begin
                            n_col = '0;
                        end
                        CODE_BACKSPACE: begin
                            if (r_col == '0) begin
                                n_state = S_IDLE;    // nothing to report
                            end else begin
                                n_col = r_col - 1'b1;
                            end
                        end
                        CODE_FORM_FEED: begin
                            n_clear_all = 1'b1;
                            n_cell_data = {r_attr, CODE_SPACE};
                            n_row       = '0;
                            n_col       = '0;
                        end
                        default: begin
                            n_state = S_IDLE;        // unknown code, no result
                        end
                    endcase
                end
            end
            S_POS: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_xfer) begin
                    n_state = r_last ? S_IDLE : S_CALC;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row     <= '0;
            r_col     <= '0;
            r_attr    <= ATTR_RESET;
            r_tab_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            if (i_text_attribute_we) begin
                r_attr <= i_text_attribute;
            end
            if (w_accept) begin
                r_tab_cnt <= '0;
            end else if (w_out_xfer) begin
                r_tab_cnt <= r_tab_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_code <= i_char_code;
        end
        r_cell_write <= n_cell_write;
        r_clear_all  <= n_clear_all;
        r_cell_addr  <= n_cell_addr;
        r_cell_data  <= n_cell_data;
        r_last       <= n_last;
        if (r_state == S_POS) begin
            r_cursor_pos <= w_pos;   // cursor already moved in S_CALC
        end
    end

    assign o_char_code_ready = (r_state == S_IDLE);
    assign o_result_valid    = (r_state == S_OUT);
    assign o_cell_write      = r_cell_write;
    assign o_clear_all       = r_clear_all;
    assign o_cell_addr       = r_cell_addr;
    assign o_cell_data       = r_cell_data;
    assign o_cursor_pos      = r_cursor_pos;
    assign o_last_of_run     = r_last;

endmodule

/* rtl/tcon_checker.sv */
// Port-level checks for the text console character engine, with bind.
module tcon_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_char_code_valid,
    input logic                            o_char_code_ready,
    input logic                            o_result_valid,
    input logic                            i_result_ready,
    input logic                            o_cell_write,
    input logic                            o_clear_all,
    input logic [tcon_pkg::ADDR_W-1:0]     o_cell_addr,
    input logic [tcon_pkg::ADDR_W-1:0]     o_cursor_pos,
    input logic                            o_last_of_run
);
    import tcon_pkg::*;

    // a pending result is held until its transfer
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !i_result_ready) |=> o_result_valid)
        else $error("result dropped before transfer");

    // one item at a time: no input while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !o_char_code_ready)
        else $error("input ready while result pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_char_code_valid && o_char_code_ready) |=> !o_char_code_ready)
        else $error("ready right after input transfer");

    a_write_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !(o_cell_write && o_clear_all))
        else $error("cell write and clear together");

    a_clear_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_clear_all) |->
            (o_cursor_pos == '0 && o_cell_addr == '0 && o_last_of_run))
        else $error("clear result not homed");

endmodule

bind text_console_char_engine tcon_checker u_tcon_checker (.*);
